// ===== design/ersa_pkg.sv =====
// ----------------------------------------------------------------------------
// ersa_pkg: shared types and constants of the expiry ring slot allocator
// Field widths, result codes, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ersa_pkg;

	// field widths
	localparam int DATA_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int SLOT_W    = 15;
	localparam int STATUS_W  = 2;
	localparam int OUT_PAD_W = 16;

	// width for the ring growth arithmetic (doubled size of a 17-bit ring)
	localparam int GROW_W     = 18;
	localparam int GROW_SHIFT = 1;

	// register reset values and backoff window
	localparam logic [CFG_W-1:0]  MAX_RESET     = 16'd32768;
	localparam logic [CFG_W-1:0]  MIN_RESET     = 16'd1024;
	localparam logic [DATA_W-1:0] BACKOFF_STEPS = 32'd3;

	// input item kinds
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLOTS = 1'b1;

	// result codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_TICK   = 2'd0,
		STATUS_GRANT  = 2'd1,
		STATUS_REFUSE = 2'd2,
		STATUS_DROP   = 2'd3
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		ST_INIT_CLR,
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_GROW_CLR,
		ST_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic decide;
		logic scan;
		logic sweep;
		logic out_load;
	} ersa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic refused;
		logic hit;
		logic exhausted;
		logic grow_full;
		logic grow_no_clear;
		logic sweep_last;
		logic out_free;
	} ersa_sts_t;

endpackage

// ===== design/ersa_ram.sv =====
// ----------------------------------------------------------------------------
// ersa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ersa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/ersa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ersa_ctrl: sequencer of the slot allocator
// Walks the reset clear, item decode, ring scan, growth clear and result
// handoff, driving the datapath by command bundle.
// ----------------------------------------------------------------------------
module ersa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ersa_pkg::ersa_sts_t sts,
	output ersa_pkg::ersa_cmd_t cmd
);

	import ersa_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_INIT_CLR: begin
				if (sts.sweep_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.is_tick || sts.refused) state_nxt = ST_RESP;
				else state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.hit) begin
					state_nxt = ST_RESP;
				end else if (sts.exhausted) begin
					if (sts.grow_full || sts.grow_no_clear) state_nxt = ST_RESP;
					else state_nxt = ST_GROW_CLR;
				end
			end
			ST_GROW_CLR: begin
				if (sts.sweep_last) state_nxt = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_INIT_CLR;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		unique case (state_q)
			ST_INIT_CLR: cmd.sweep = 1'b1;
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			ST_DECIDE:   cmd.decide = 1'b1;
			ST_SCAN:     cmd.scan = 1'b1;
			ST_GROW_CLR: cmd.sweep = 1'b1;
			ST_RESP:     cmd.out_load = sts.out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// a scan never hits and runs dry in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !(sts.hit && sts.exhausted))
		else $error("scan hit and exhaustion together");

endmodule

// ===== design/ersa_dp.sv =====
// ----------------------------------------------------------------------------
// ersa_dp: datapath of the slot allocator
// Configuration and ring registers, scan pipeline over the expiry RAM,
// growth sizing, clear sweep and the result output register.
// ----------------------------------------------------------------------------
module ersa_dp #(
	parameter int CAPACITY = 32768
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ersa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ersa_pkg::CFG_W-1:0]            cfg_data,
	// input item fields
	input  logic                                  in_kind,
	input  logic [ersa_pkg::DATA_W-1:0]           in_now_time,
	input  logic [ersa_pkg::DATA_W-1:0]           in_step_number,
	input  logic [ersa_pkg::DATA_W-1:0]           in_expiry_time,
	// result register
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [ersa_pkg::STATUS_W-1:0]         out_status,
	output logic [ersa_pkg::SLOT_W-1:0]           out_slot,
	output logic                                  out_grew,
	// controller
	input  ersa_pkg::ersa_cmd_t                   cmd,
	output ersa_pkg::ersa_sts_t                   sts
);

	import ersa_pkg::*;

	localparam int AW      = $clog2(CAPACITY);
	localparam int SW      = $clog2(CAPACITY + 1);
	localparam int ACT_RST = (int'(MIN_RESET) < CAPACITY) ? int'(MIN_RESET) : CAPACITY;

	// configuration and ring state
	logic [CFG_W-1:0]  max_q, min_q;
	logic [DATA_W-1:0] time_q, step_q, last_q;
	logic [SW-1:0]     active_q;
	logic [AW-1:0]     add_q;

	// latched item
	logic              kind_q;
	logic [DATA_W-1:0] now_in_q, step_in_q, exp_q;

	// scan pipeline
	logic [AW-1:0]     issue_pos_q;
	logic [SW-1:0]     left_q;
	logic [AW-1:0]     end_q;
	logic              cmp_valid_s1;
	logic [AW-1:0]     cmp_pos_s1;
	logic [SW-1:0]     grow_size_q;
	logic              grow_full_q;

	// clear sweep
	logic [AW-1:0]     sweep_q;
	logic [AW-1:0]     clr_end_q;

	// pending result and output register
	status_t           res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_grew_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_grew_q;

	// RAM ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;

	// combinational helpers
	logic [GROW_W-1:0] eff_max_x, act_x, dbl_x, lo_x, grow_x;
	logic              grow_full_c;
	logic [AW-1:0]     start_pos, end_pos;
	logic [SW-1:0]     issue_inc, hit_inc, old_inc;
	logic [AW-1:0]     issue_nxt, hit_nxt;
	logic              hit, exhausted;

	// growth sizing: double, floor at min, ceiling at effective max
	always_comb begin
		eff_max_x   = (GROW_W'(max_q) < GROW_W'(CAPACITY)) ? GROW_W'(max_q)
		                                                   : GROW_W'(CAPACITY);
		act_x       = GROW_W'(active_q);
		dbl_x       = act_x << GROW_SHIFT;
		lo_x        = (dbl_x < GROW_W'(min_q)) ? GROW_W'(min_q) : dbl_x;
		grow_x      = (lo_x > eff_max_x) ? eff_max_x : lo_x;
		grow_full_c = (act_x >= eff_max_x) || (grow_x <= act_x);
	end

	// scan window: start at the add position, stop short of the slot before it
	always_comb begin
		start_pos = (SW'(add_q) < active_q) ? add_q : '0;
		if (active_q == '0) end_pos = add_q;
		else if (start_pos == '0) end_pos = AW'(active_q - SW'(1));
		else end_pos = start_pos - AW'(1);
	end

	// ring wraparound of the scan positions
	always_comb begin
		issue_inc = SW'(issue_pos_q) + SW'(1);
		issue_nxt = (issue_inc == active_q) ? '0 : AW'(issue_inc);
		hit_inc   = SW'(cmp_pos_s1) + SW'(1);
		hit_nxt   = (hit_inc == active_q) ? '0 : AW'(hit_inc);
		old_inc   = active_q + SW'(1);
	end

	assign hit       = cmp_valid_s1 && (ram_rdata <= time_q);
	assign exhausted = !cmp_valid_s1 && (left_q == '0);

	// status to the controller
	always_comb begin
		sts.is_tick       = (kind_q == KIND_TICK);
		sts.refused       = (max_q == '0) || (step_q < (last_q + BACKOFF_STEPS));
		sts.hit           = hit;
		sts.exhausted     = exhausted;
		sts.grow_full     = grow_full_q;
		sts.grow_no_clear = (old_inc == grow_size_q);
		sts.sweep_last    = (sweep_q == clr_end_q);
		sts.out_free      = !out_valid_q || out_ready;
	end

	// RAM write port: clear sweep, scan grant or first grown slot
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = '0;
		if (cmd.sweep) begin
			ram_we = 1'b1;
		end else if (cmd.scan && hit) begin
			ram_we    = 1'b1;
			ram_waddr = cmp_pos_s1;
			ram_wdata = exp_q;
		end else if (cmd.scan && exhausted && !grow_full_q) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(active_q);
			ram_wdata = exp_q;
		end
	end

	ersa_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(issue_pos_q),
		.rdata(ram_rdata)
	);

	// ring state, scan control and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q        <= MAX_RESET;
			min_q        <= MIN_RESET;
			time_q       <= '0;
			step_q       <= '0;
			last_q       <= '0;
			active_q     <= SW'(ACT_RST);
			add_q        <= '0;
			left_q       <= '0;
			cmp_valid_s1 <= 1'b0;
			sweep_q      <= '0;
			clr_end_q    <= AW'(CAPACITY - 1);
			out_valid_q  <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MAX_SLOTS: max_q <= cfg_data;
					CFG_MIN_SLOTS: min_q <= cfg_data;
				endcase
			end

			// tick, or arm the scan of an allocation
			if (cmd.decide) begin
				if (kind_q == KIND_TICK) begin
					time_q <= now_in_q;
					step_q <= step_in_q;
					if (act_x > GROW_W'(max_q)) begin
						active_q <= SW'(eff_max_x);
						add_q    <= '0;
					end
				end else begin
					left_q       <= (active_q == '0) ? '0 : active_q - SW'(1);
					cmp_valid_s1 <= 1'b0;
				end
			end

			// one read issued per cycle, compared in the next cycle
			if (cmd.scan) begin
				if (left_q != '0) begin
					left_q       <= left_q - SW'(1);
					cmp_valid_s1 <= 1'b1;
				end else begin
					cmp_valid_s1 <= 1'b0;
				end
				if (hit) begin
					add_q <= hit_nxt;
				end else if (exhausted) begin
					if (grow_full_q) begin
						add_q  <= end_q;
						last_q <= step_q;
					end else begin
						active_q  <= grow_size_q;
						add_q     <= sts.grow_no_clear ? '0 : AW'(old_inc);
						sweep_q   <= AW'(old_inc);
						clr_end_q <= AW'(grow_size_q - SW'(1));
					end
				end
			end

			// clear sweep
			if (cmd.sweep) begin
				sweep_q <= sweep_q + AW'(1);
			end

			// output register
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item, scan positions and result payload
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q    <= in_kind;
			now_in_q  <= in_now_time;
			step_in_q <= in_step_number;
			exp_q     <= in_expiry_time;
		end

		if (cmd.decide) begin
			issue_pos_q <= start_pos;
			end_q       <= end_pos;
			grow_size_q <= SW'(grow_x);
			grow_full_q <= grow_full_c;
			if (kind_q == KIND_TICK) begin
				res_status_q <= STATUS_TICK;
			end else begin
				res_status_q <= STATUS_REFUSE;
			end
			res_slot_q <= '0;
			res_grew_q <= 1'b0;
		end

		if (cmd.scan) begin
			if (left_q != '0) begin
				issue_pos_q <= issue_nxt;
				cmp_pos_s1  <= issue_pos_q;
			end
			if (hit) begin
				res_status_q <= STATUS_GRANT;
				res_slot_q   <= SLOT_W'(cmp_pos_s1);
				res_grew_q   <= 1'b0;
			end else if (exhausted) begin
				if (grow_full_q) begin
					res_status_q <= STATUS_DROP;
					res_slot_q   <= '0;
					res_grew_q   <= 1'b0;
				end else begin
					res_status_q <= STATUS_GRANT;
					res_slot_q   <= SLOT_W'(active_q);
					res_grew_q   <= 1'b1;
				end
			end
		end

		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_grew_q   <= res_grew_q;
		end
	end

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;
	assign out_grew   = out_grew_q;

	// the ring never outgrows the store
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(active_q) <= CAPACITY)
		else $error("active ring larger than capacity");

	// a granted scan slot lies inside the ring
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && hit) |-> (SW'(cmp_pos_s1) < active_q))
		else $error("scan grant outside the ring");

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

endmodule

// ===== design/expiry_ring_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// expiry_ring_slot_allocator_unit: slot allocator over a ring of expiry times
// Ticks set time and step and trim the ring to the limit; allocations scan
// the ring for an expired slot, grow it when none is free, or are refused or dropped.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  --------  ---------  -----------------------------  ---------------------------
//  cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata times, tuser kind
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata slot, tuser status,grew
//
//  Tick and refused allocations go from decode straight to the respond step.
//  An allocation scans the ring one slot read per cycle, through the single
//  read port of the expiry RAM, and grants the first expired slot it reads.
//  Growing the ring clears each newly added slot beyond the first.
//  After reset the whole RAM is cleared with s_axis_tready low.
//  A result stalled on m_axis holds the next item in the respond step.
// ----------------------------------------------------------------------------
module expiry_ring_slot_allocator_unit #(
	parameter int CAPACITY = 32768
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ersa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ersa_pkg::CFG_W-1:0]            cfg_data,
	// input items
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [3*ersa_pkg::DATA_W-1:0]         s_axis_tdata,  // now_time, step_number, expiry_time
	input  logic [0:0]                            s_axis_tuser,  // kind
	// results
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [ersa_pkg::OUT_PAD_W-1:0]        m_axis_tdata,  // slot, zero pad
	output logic [ersa_pkg::STATUS_W:0]           m_axis_tuser   // status, grew
);

	import ersa_pkg::*;

	ersa_cmd_t         cmd;
	ersa_sts_t         sts;
	logic [STATUS_W-1:0] res_status;
	logic [SLOT_W-1:0]   res_slot;
	logic                res_grew;

	ersa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ersa_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_kind       (s_axis_tuser[0]),
		.in_now_time   (s_axis_tdata[DATA_W-1:0]),
		.in_step_number(s_axis_tdata[2*DATA_W-1:DATA_W]),
		.in_expiry_time(s_axis_tdata[3*DATA_W-1:2*DATA_W]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_status    (res_status),
		.out_slot      (res_slot),
		.out_grew      (res_grew),
		.cmd           (cmd),
		.sts           (sts)
	);

	// result packing
	assign m_axis_tdata = OUT_PAD_W'(res_slot);
	assign m_axis_tuser = {res_grew, res_status};

endmodule

// ===== dv/tb_expiry_ring_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_expiry_ring_slot_allocator_unit: self-checking bench of the slot allocator
// A short directed table covers reset state, backoff, full rings, the disabled
// ring, growth from an empty ring and growth up to capacity. About 550 random
// ticks and allocations follow over several ring limits. Every result is
// checked against an in-bench model of the expiry ring or against the
// expected value of its table row. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_expiry_ring_slot_allocator_unit;
	import ersa_pkg::*;

	localparam int CAPACITY      = 32768;
	localparam int CYCLE_LIMIT   = 30_000_000;
	localparam int RAND_ITEMS    = 550;
	localparam int PHASE_LEN     = 110;
	localparam int IDLE_PCT      = 22;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic              kind;
		logic [DATA_W-1:0] now_time;
		logic [DATA_W-1:0] step_number;
		logic [DATA_W-1:0] expiry_time;
	} ring_item_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic              grew;
	} alloc_result_t;

	// one row of the directed table: a register write or an item
	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     reg_val;
		ring_item_t           item;
		bit                   typed;
		alloc_result_t        want;
	} plan_row_t;

	logic                        clk           = 1'b0;
	logic                        arst_n        = 1'b0;
	logic                        cfg_valid     = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index     = '0;
	logic [CFG_W-1:0]            cfg_data      = '0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [3*DATA_W-1:0]         s_axis_tdata  = '0;  // now_time, step_number, expiry_time
	logic [0:0]                  s_axis_tuser  = '0;  // kind
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [OUT_PAD_W-1:0]        m_axis_tdata;        // slot, zero pad
	logic [STATUS_W:0]           m_axis_tuser;        // status, grew

	// model of the expiry ring
	bit [DATA_W-1:0]   ring_expiry [CAPACITY];
	int unsigned       ring_pos  = 0;
	int unsigned       ring_size = 32'(MIN_RESET);
	logic [DATA_W-1:0] ring_now  = '0;
	logic [DATA_W-1:0] ring_step = '0;
	logic [DATA_W-1:0] ring_ovf  = '0;
	int unsigned       lim_max   = 32'(MAX_RESET);
	int unsigned       lim_min   = 32'(MIN_RESET);

	alloc_result_t pending [$];
	plan_row_t     plan [$];

	logic [CFG_W-1:0] phase_max [5] = '{16'd16, 16'd64, 16'd5, 16'd2, 16'd32768};
	logic [CFG_W-1:0] phase_min [5] = '{16'd4, 16'd1, 16'd2, 16'd1, 16'd8};

	bit          calm = 1'b0;
	int          errors = 0;
	int unsigned cycles = 0;
	int          n_items = 0, n_cfg = 0;
	int          n_tick = 0, n_grant = 0, n_grow = 0, n_refuse = 0, n_drop = 0;
	logic [DATA_W-1:0] gen_time = 32'd1000;
	logic [DATA_W-1:0] gen_step = 32'h200;

	expiry_ring_slot_allocator_unit #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// advance the ring model by one item and return its result
	function automatic alloc_result_t predict(input ring_item_t it);
		alloc_result_t     r;
		int unsigned       pos, stop, old, grown, top;
		logic [DATA_W-1:0] backoff_end;
		bit                hit;
		r.status    = STATUS_TICK;
		r.slot      = '0;
		r.grew      = 1'b0;
		hit         = 1'b0;
		top         = (lim_max < CAPACITY) ? lim_max : CAPACITY;
		backoff_end = ring_ovf + BACKOFF_STEPS;
		if (it.kind == KIND_TICK) begin
			ring_now  = it.now_time;
			ring_step = it.step_number;
			if (ring_size > lim_max) begin
				ring_size = top;
				ring_pos  = 0;
			end
		end else if (lim_max == 0 || ring_step < backoff_end) begin
			r.status = STATUS_REFUSE;
		end else begin
			// one lap of the ring; the slot just before the start is never visited
			if (ring_size != 0) begin
				pos  = (ring_pos < ring_size) ? ring_pos : 0;
				stop = (pos == 0) ? ring_size - 1 : pos - 1;
				while (pos != stop && !hit) begin
					if (ring_expiry[pos] <= ring_now) begin
						hit              = 1'b1;
						ring_expiry[pos] = it.expiry_time;
						r.status         = STATUS_GRANT;
						r.slot           = pos[SLOT_W-1:0];
						ring_pos         = (pos + 1) % ring_size;
					end else begin
						pos = (pos + 1) % ring_size;
					end
				end
				if (!hit)
					ring_pos = pos;
			end
			// nothing free: grow the ring or drop the request
			if (!hit) begin
				old   = ring_size;
				grown = old * 2;
				if (grown < lim_min)
					grown = lim_min;
				if (grown > top)
					grown = top;
				if (old >= top || grown <= old) begin
					ring_ovf = ring_step;
					r.status = STATUS_DROP;
				end else begin
					for (int unsigned k = old; k < grown; k++)
						ring_expiry[k] = '0;
					ring_size        = grown;
					ring_expiry[old] = it.expiry_time;
					ring_pos         = (old + 1) % grown;
					r.status         = STATUS_GRANT;
					r.slot           = old[SLOT_W-1:0];
					r.grew           = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic void plan_item(input logic kind, input logic [DATA_W-1:0] t, s, e,
			input bit typed = 1'b0, input status_t st = STATUS_TICK,
			input logic [SLOT_W-1:0] sl = '0, input logic gr = 1'b0);
		plan_row_t row;
		row.is_cfg           = 1'b0;
		row.reg_idx          = '0;
		row.reg_val          = '0;
		row.item.kind        = kind;
		row.item.now_time    = t;
		row.item.step_number = s;
		row.item.expiry_time = e;
		row.typed            = typed;
		row.want.status      = st;
		row.want.slot        = sl;
		row.want.grew        = gr;
		plan.insert(plan.size(), row);
	endfunction

	function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		plan_row_t row;
		row.is_cfg  = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		row.item    = '0;
		row.typed   = 1'b0;
		row.want    = '0;
		plan.insert(plan.size(), row);
	endfunction

	// one input transaction, with a random gap in front of it
	task automatic send_item(input ring_item_t it, input bit typed, input alloc_result_t want);
		alloc_result_t r;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {it.expiry_time, it.step_number, it.now_time};
		s_axis_tuser  <= it.kind;
		do @(posedge clk); while (!s_axis_tready);
		r = predict(it);
		if (typed)
			pending.insert(pending.size(), want);
		else
			pending.insert(pending.size(), r);
		n_items++;
	endtask

	// register write once the block has drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MAX_SLOTS)
			lim_max = 32'(val);
		else
			lim_min = 32'(val);
		n_cfg++;
	endtask

	// result checker
	always @(posedge clk) begin
		alloc_result_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending.size() == 0) begin
				$error("result with nothing pending: status %0d slot %0d grew %0d",
					m_axis_tuser[STATUS_W-1:0], m_axis_tdata[SLOT_W-1:0], m_axis_tuser[STATUS_W]);
				errors++;
			end else begin
				w = pending.pop_front();
				case (w.status)
					STATUS_TICK:   n_tick++;
					STATUS_GRANT:  n_grant++;
					STATUS_REFUSE: n_refuse++;
					default:       n_drop++;
				endcase
				if (w.grew)
					n_grow++;
				if (m_axis_tuser[STATUS_W-1:0] !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, m_axis_tuser[STATUS_W-1:0]);
					errors++;
				end
				if (m_axis_tdata[SLOT_W-1:0] !== w.slot) begin
					$error("slot: expected %0d, got %0d", w.slot, m_axis_tdata[SLOT_W-1:0]);
					errors++;
				end
				if (m_axis_tuser[STATUS_W] !== w.grew) begin
					$error("grew: expected %0d, got %0d", w.grew, m_axis_tuser[STATUS_W]);
					errors++;
				end
				if (m_axis_tdata[OUT_PAD_W-1:SLOT_W] !== '0) begin
					$error("tdata pad: expected 0, got %0h", m_axis_tdata[OUT_PAD_W-1:SLOT_W]);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		ring_item_t    it;
		alloc_result_t none;
		int            r;
		none = '0;

		// reset state: backoff window is still open, the store is all free
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd5, 1'b1, STATUS_REFUSE);
		plan_item(KIND_TICK, 32'd0, 32'd3, 32'd0, 1'b1, STATUS_TICK);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'hffff_ffff, 1'b1, STATUS_GRANT, 15'd0);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd0, 1'b1, STATUS_GRANT, 15'd1);
		plan_item(KIND_TICK, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, STATUS_TICK);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'h1234_5678);
		// shrink to four slots, fill it, drop, then wait out the backoff
		plan_cfg(CFG_MAX_SLOTS, 16'd4);
		plan_cfg(CFG_MIN_SLOTS, 16'd1);
		plan_item(KIND_TICK, 32'd100, 32'd10, 32'd0, 1'b1, STATUS_TICK);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd200);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd200);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd200);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd200);
		plan_item(KIND_TICK, 32'd100, 32'd12, 32'd0);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd200);
		plan_item(KIND_TICK, 32'd250, 32'd13, 32'd0);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd300);
		// overflow at the last step: backoff end wraps past zero
		plan_item(KIND_TICK, 32'd250, 32'hffff_ffff, 32'd0);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'hffff_fff0);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd1);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd1);
		// disabled ring, then an empty ring that cannot or can grow
		plan_cfg(CFG_MAX_SLOTS, 16'd0);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd1, 1'b1, STATUS_REFUSE);
		plan_item(KIND_TICK, 32'd0, 32'h100, 32'd0, 1'b1, STATUS_TICK);
		plan_cfg(CFG_MAX_SLOTS, 16'd8);
		plan_cfg(CFG_MIN_SLOTS, 16'd0);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd9, 1'b1, STATUS_DROP);
		plan_item(KIND_TICK, 32'd0, 32'h103, 32'd0);
		plan_cfg(CFG_MIN_SLOTS, 16'd1);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd9, 1'b1, STATUS_GRANT, 15'd0, 1'b1);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd7);
		// limit above capacity and minimum at capacity: one growth to full capacity
		plan_cfg(CFG_MAX_SLOTS, 16'hffff);
		plan_cfg(CFG_MIN_SLOTS, 16'h8000);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd5);
		plan_item(KIND_ALLOC, 32'd0, 32'd0, 32'd1);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			else
				send_item(plan[i].item, plan[i].typed, plan[i].want);
		end

		// random traffic: mostly time moving forward with short-lived slots
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % PHASE_LEN == 0) begin
				write_reg(CFG_MAX_SLOTS, phase_max[i / PHASE_LEN]);
				write_reg(CFG_MIN_SLOTS, phase_min[i / PHASE_LEN]);
			end
			calm = (i >= 200 && i < 320);
			r = $urandom_range(0, 99);
			it.now_time    = $urandom;
			it.step_number = $urandom;
			it.expiry_time = $urandom;
			if (r < 8) begin
				// noise; steps stay in the lower half so a drop cannot block later steps
				it.kind        = 1'($urandom_range(0, 1));
				it.step_number = it.step_number & 32'h7fff_ffff;
				if (it.kind == KIND_TICK && it.step_number >= gen_step)
					gen_step = it.step_number;
			end else if (r < 36) begin
				gen_time       = gen_time + $urandom_range(0, 40);
				gen_step       = gen_step + $urandom_range(0, 2);
				it.kind        = KIND_TICK;
				it.now_time    = gen_time;
				it.step_number = gen_step;
			end else begin
				it.kind        = KIND_ALLOC;
				it.expiry_time = gen_time + $urandom_range(1, 150);
			end
			send_item(it, 1'b0, none);
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items over %0d register writes, ring limits 0 to above capacity.",
			n_items, n_cfg);
		$display("Results: %0d ticks, %0d grants (%0d by growth), %0d refused, %0d dropped.",
			n_tick, n_grant, n_grow, n_refuse, n_drop);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
